>>> sv/hcr_pkg.sv
// Package: shared constants and types for the handshake checksum receiver.
package hcr_pkg;

  localparam int FRAME_BYTES = 16;

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_BYTES - 1);

  localparam logic [7:0] REQ_BYTE  = 8'hAA;
  localparam logic [7:0] ACK_BYTE  = 8'hBB;
  localparam logic [7:0] GOOD_BYTE = 8'h00;
  localparam logic [7:0] BAD_BYTE  = 8'hFF;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // write request into the frame store
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } hcr_wr_t;

endpackage

>>> sv/hcr_frame_store.sv
// Frame store: single-port-write, registered-read byte memory for one frame.
module hcr_frame_store
  import hcr_pkg::*;
(
  input  logic             clk,
  input  hcr_wr_t          wr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    // data holds until the next read
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/handshake_checksum_receiver_top.sv
// Top level: handshake checksum receiver, frame control and output register.
//
// Receiving end of a serial point-to-point link, fed one received byte per
// input beat. While waiting it drops every byte but the request 0xAA, which
// it answers with a 0xBB reply beat. It then stores FRAME_BYTES payload
// bytes in an on-chip frame store while keeping an 8-bit wrapping sum; the
// byte after them is the checksum. On a match it emits a 0x00 reply beat
// followed by the stored bytes in order (kind = 1, last on the final one)
// and goes back to waiting. On a mismatch it emits a 0xFF reply beat (last
// set) and starts a fresh frame without a new request. Throughput: one
// input beat per cycle while waiting or receiving; the input is stalled
// only while the output register holds a beat that has not been taken.
// After a good checksum the payload release runs from the frame store: each
// byte is read in ST_RD and moved into the output register in ST_LD, and the
// block accepts no input byte until the whole release is done. No
// clearing pass is needed after reset: every entry is written before it
// is ever read.
module handshake_checksum_receiver_top
  import hcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_value,
  output logic       out_last
);

  // ST_WAIT: idle, looking for request
  // ST_RECV: taking payload bytes and then the checksum
  // ST_RD:   read of the next stored byte issued
  // ST_LD:   stored byte available, move it into the output register
  typedef enum logic [1:0] {
    ST_WAIT,
    ST_RECV,
    ST_RD,
    ST_LD
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // payload bytes taken
  logic [7:0]       sum_r, sum_nxt;     // wrapping payload sum
  logic [IDX_W-1:0] idx_r, idx_nxt;     // release pointer

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [7:0]       out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  hcr_wr_t          wr;
  logic             rd_en;
  logic [7:0]       rd_data;

  logic             out_free;
  logic             in_fire;

  // Output register can take a new beat when empty or draining this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(((state_r == ST_WAIT) || (state_r == ST_RECV)) && out_free);
  assign in_fire  = in_valid && !in_stall;

  hcr_frame_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_idx  (idx_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    wr.en         = 1'b0;
    wr.idx        = cnt_r[IDX_W-1:0];
    wr.data       = in_rx_byte;
    rd_en         = 1'b0;

    unique case (state_r)
      ST_WAIT: begin
        if (in_fire && (in_rx_byte == REQ_BYTE)) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REPLY;
          out_value_nxt = ACK_BYTE;
          out_last_nxt  = 1'b1;
          cnt_nxt       = '0;
          sum_nxt       = '0;
          state_nxt     = ST_RECV;
        end
      end
      ST_RECV: begin
        if (in_fire) begin
          if (cnt_r < FRAME_CNT) begin
            // payload byte: store and accumulate
            wr.en   = 1'b1;
            sum_nxt = sum_r + in_rx_byte;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            // checksum byte
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REPLY;
            cnt_nxt       = '0;
            sum_nxt       = '0;
            if (in_rx_byte == sum_r) begin
              out_value_nxt = GOOD_BYTE;
              out_last_nxt  = 1'b0;
              idx_nxt       = '0;
              state_nxt     = ST_RD;
            end else begin
              out_value_nxt = BAD_BYTE;
              out_last_nxt  = 1'b1;
            end
          end
        end
      end
      ST_RD: begin
        rd_en     = 1'b1;
        state_nxt = ST_LD;
      end
      ST_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DATA;
          out_value_nxt = rd_data;
          out_last_nxt  = (idx_r == LAST_IDX);
          if (idx_r == LAST_IDX) begin
            state_nxt = ST_WAIT;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      cnt_r       <= '0;
      sum_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule
